>>> design/wsfu_pkg.sv
package wsfu_pkg;

  // Result status codes
  localparam logic [2:0] ST_DATA       = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_NOTFINMASK = 3'd2;
  localparam logic [2:0] ST_LEN64      = 3'd3;
  localparam logic [2:0] ST_TOOLONG    = 3'd4;

  // Header constants
  localparam logic [7:0] FIRST_BYTE_MASK = 8'h81;
  localparam logic [6:0] LEN_CODE_EXT16  = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64  = 7'd127;

  localparam int unsigned MAX_LEN_W      = 17;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 17'd1024;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] status;
    logic       last;
  } out_word_t;

endpackage

>>> design/websocket_frame_unmasker.sv
// Client-to-server WebSocket frame unmasker.
// Input channel (in_valid / in_stall / in_data) carries one frame byte per
// word, with frame_start marking the first byte of each frame. A word is
// taken at a clock edge where in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall / out_data) carries unmasked payload
// bytes and status words (empty frame, header rejections); last marks the
// final payload byte and every status word.
// Results are registered: a result appears in the cycle after the input word that causes it.
// Throughput: one input word per cycle while in_stall is low; the header
// check, length capture and key XOR all sit in one stage in front of the output register.
// When the receiver stalls, the output register holds its word and in_stall
// rises only while that register is full and stalled.
// The configuration channel (cfg_valid / cfg_ready / cfg_data) writes the
// maximum extended length; cfg_ready is always high, and writes belong in
// idle periods.
// Reset (rst, synchronous) returns the parser to idle, empties the output
// register and sets the maximum length to 1024.
module websocket_frame_unmasker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  wsfu_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output wsfu_pkg::out_word_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wsfu_pkg::MAX_LEN_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_KEY  = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  phase_t                          phase, phase_next;
  logic [1:0]                      hdr_count, hdr_count_next;
  logic [15:0]                     payload_remaining, payload_remaining_next;
  logic [31:0]                     mask_key, mask_key_next;
  logic [1:0]                      key_index, key_index_next;
  logic [wsfu_pkg::MAX_LEN_W-1:0]  max_len;
  logic                            emit;
  wsfu_pkg::out_word_t             result;
  logic                            in_accept;
  logic [15:0]                     ext_len;
  logic [7:0]                      key_byte;
  logic [15:0]                     remaining_dec;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign ext_len       = {payload_remaining[7:0], in_data.rx_byte};
  assign key_byte      = mask_key[8*key_index +: 8];
  assign remaining_dec = payload_remaining - 16'd1;

  // Parse one byte: advance the header state and form the result word
  always_comb begin
    phase_next             = phase;
    hdr_count_next         = hdr_count;
    payload_remaining_next = payload_remaining;
    mask_key_next          = mask_key;
    key_index_next         = key_index;
    emit                   = 1'b0;
    result                 = '0;
    if (in_data.frame_start) begin
      hdr_count_next         = 2'd0;
      payload_remaining_next = 16'd0;
      mask_key_next          = 32'd0;
      key_index_next         = 2'd0;
      if ((in_data.rx_byte & wsfu_pkg::FIRST_BYTE_MASK) != wsfu_pkg::FIRST_BYTE_MASK) begin
        phase_next    = PH_IDLE;
        emit          = 1'b1;
        result.status = wsfu_pkg::ST_NOTFINMASK;
        result.last   = 1'b1;
      end else begin
        phase_next = PH_LEN;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_LEN: begin
          if (!in_data.rx_byte[7]) begin
            phase_next     = PH_IDLE;
            hdr_count_next = 2'd0;
            emit           = 1'b1;
            result.status  = wsfu_pkg::ST_NOTFINMASK;
            result.last    = 1'b1;
          end else if (in_data.rx_byte[6:0] == wsfu_pkg::LEN_CODE_EXT64) begin
            phase_next     = PH_IDLE;
            hdr_count_next = 2'd0;
            emit           = 1'b1;
            result.status  = wsfu_pkg::ST_LEN64;
            result.last    = 1'b1;
          end else if (in_data.rx_byte[6:0] == wsfu_pkg::LEN_CODE_EXT16) begin
            hdr_count_next         = 2'd0;
            payload_remaining_next = 16'd0;
            phase_next             = PH_EXT;
          end else begin
            hdr_count_next         = 2'd0;
            payload_remaining_next = {9'd0, in_data.rx_byte[6:0]};
            phase_next             = PH_KEY;
          end
        end
        PH_EXT: begin
          payload_remaining_next = ext_len;
          if (hdr_count == 2'd1) begin
            hdr_count_next = 2'd0;
            if ({1'b0, ext_len} >= max_len) begin
              phase_next    = PH_IDLE;
              emit          = 1'b1;
              result.status = wsfu_pkg::ST_TOOLONG;
              result.last   = 1'b1;
            end else begin
              phase_next = PH_KEY;
            end
          end else begin
            hdr_count_next = hdr_count + 2'd1;
          end
        end
        PH_KEY: begin
          mask_key_next[8*hdr_count +: 8] = in_data.rx_byte;
          hdr_count_next = hdr_count + 2'd1;
          if (hdr_count == 2'd3) begin
            key_index_next = 2'd0;
            if (payload_remaining == 16'd0) begin
              phase_next    = PH_IDLE;
              emit          = 1'b1;
              result.status = wsfu_pkg::ST_EMPTY;
              result.last   = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          key_index_next         = key_index + 2'd1;
          payload_remaining_next = remaining_dec;
          emit                   = 1'b1;
          result.data_byte       = in_data.rx_byte ^ key_byte;
          result.status          = wsfu_pkg::ST_DATA;
          result.last            = (remaining_dec == 16'd0);
          if (remaining_dec == 16'd0) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Hold parser state; advance only on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      hdr_count         <= 2'd0;
      payload_remaining <= 16'd0;
      mask_key          <= 32'd0;
      key_index         <= 2'd0;
    end else if (in_accept) begin
      phase             <= phase_next;
      hdr_count         <= hdr_count_next;
      payload_remaining <= payload_remaining_next;
      mask_key          <= mask_key_next;
      key_index         <= key_index_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= wsfu_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len <= cfg_data;
    end
  end

  // Output register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_data <= result;
    end
  end

`ifndef ASSERT_OFF
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != wsfu_pkg::ST_DATA |->
      out_data.last && out_data.data_byte == 8'd0)
    else $error("status word without last or with nonzero data");

  a_data_nonempty: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> payload_remaining != 16'd0)
    else $error("payload phase with no bytes left");

  a_key_index_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_KEY |-> key_index == 2'd0)
    else $error("key index not cleared during key capture");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
